/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clock / reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// Constants, control word type and microcode ROM of the trial division
// primality tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int NUM_WIDTH_DEF = 16;
   localparam int FIRST_DIVISOR = 2;

   localparam int PC_WIDTH   = 3;
   localparam int OP_WIDTH   = 3;
   localparam int COND_WIDTH = 3;

   // Step addresses
   localparam logic [PC_WIDTH-1:0] STEP_WAIT   = 3'd0;
   localparam logic [PC_WIDTH-1:0] STEP_SMALL  = 3'd1;
   localparam logic [PC_WIDTH-1:0] STEP_BOUND  = 3'd2;
   localparam logic [PC_WIDTH-1:0] STEP_DINIT  = 3'd3;
   localparam logic [PC_WIDTH-1:0] STEP_DSTEP  = 3'd4;
   localparam logic [PC_WIDTH-1:0] STEP_RTEST  = 3'd5;
   localparam logic [PC_WIDTH-1:0] STEP_FINISH = 3'd6;
   localparam logic [PC_WIDTH-1:0] STEP_WRAP   = 3'd7;

   // Datapath operations
   localparam logic [OP_WIDTH-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_SMALL = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_BOUND = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_DINIT = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_DSTEP = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_RTEST = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_EMIT  = 3'd7;

   // Jump conditions: jump to target when true, else fall through
   localparam logic [COND_WIDTH-1:0] C_ALWAYS     = 3'd0;
   localparam logic [COND_WIDTH-1:0] C_NO_REQ     = 3'd1;
   localparam logic [COND_WIDTH-1:0] C_LT2        = 3'd2;
   localparam logic [COND_WIDTH-1:0] C_PAST_BOUND = 3'd3;
   localparam logic [COND_WIDTH-1:0] C_CNT_MORE   = 3'd4;
   localparam logic [COND_WIDTH-1:0] C_REM_NZ     = 3'd5;
   localparam logic [COND_WIDTH-1:0] C_OUT_BUSY   = 3'd6;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [COND_WIDTH-1:0] cond;
      logic [PC_WIDTH-1:0]   target;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         STEP_WAIT:   w = '{op: OP_LOAD,  cond: C_NO_REQ,     target: STEP_WAIT};
         STEP_SMALL:  w = '{op: OP_SMALL, cond: C_LT2,        target: STEP_FINISH};
         STEP_BOUND:  w = '{op: OP_BOUND, cond: C_PAST_BOUND, target: STEP_FINISH};
         STEP_DINIT:  w = '{op: OP_DINIT, cond: C_ALWAYS,     target: STEP_DSTEP};
         STEP_DSTEP:  w = '{op: OP_DSTEP, cond: C_CNT_MORE,   target: STEP_DSTEP};
         STEP_RTEST:  w = '{op: OP_RTEST, cond: C_REM_NZ,     target: STEP_BOUND};
         STEP_FINISH: w = '{op: OP_EMIT,  cond: C_OUT_BUSY,   target: STEP_FINISH};
         STEP_WRAP:   w = '{op: OP_NONE,  cond: C_ALWAYS,     target: STEP_WAIT};
         default:     w = '{op: OP_NONE,  cond: C_ALWAYS,     target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* rtl/trial_division_prime_test.sv */
// Flow: a candidate below 2 goes from STEP_SMALL straight to STEP_FINISH;
//   otherwise divisors from 2 are tried, up to floor(n/2) for a prime n, each
//   through STEP_BOUND, STEP_DINIT, the bit-serial remainder loop and STEP_RTEST.
// Throughput: one candidate at a time; the next beat is taken in STEP_WAIT,
//   after rsp_valid rises and STEP_WRAP has passed, even while that result still waits.
// Reset: synchronous, clears the step counter and the result valid flag.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Microcoded trial division primality tester with a shared restoring
// remainder unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_candidate,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_is_prime
);

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [PC_WIDTH-1:0]  pc_ff, pc_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 verdict_ff, verdict_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_is_prime_ff, rsp_is_prime_in;

   ucode_word_type       uw;
   logic                 cond_true;
   logic                 out_busy;
   logic                 n_lt2;
   logic [NUM_WIDTH-1:0] half_n;
   logic [NUM_WIDTH-1:0] rem_shift;

   assign uw        = ucode_rom(pc_ff);
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign n_lt2     = n_ff < NUM_WIDTH'(FIRST_DIVISOR);
   assign half_n    = n_ff >> 1;
   assign rem_shift = {rem_ff[NUM_WIDTH-2:0], quo_ff[NUM_WIDTH-1]};

   always_comb begin
      unique case (uw.cond)
         C_ALWAYS:     cond_true = 1'b1;
         C_NO_REQ:     cond_true = !req_valid;
         C_LT2:        cond_true = n_lt2;
         C_PAST_BOUND: cond_true = d_ff > half_n;
         C_CNT_MORE:   cond_true = cnt_ff != CNT_WIDTH'(1);
         C_REM_NZ:     cond_true = rem_ff != '0;
         C_OUT_BUSY:   cond_true = out_busy;
         default:      cond_true = 1'b1;
      endcase
   end

   assign pc_in = cond_true ? uw.target : pc_ff + PC_WIDTH'(1);

   always_comb begin
      n_in            = n_ff;
      d_in            = d_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      verdict_in      = verdict_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      rsp_valid_in    = out_busy;
      unique case (uw.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            n_in = req_candidate;
            d_in = NUM_WIDTH'(FIRST_DIVISOR);
         end
         OP_SMALL: verdict_in = 1'b0;
         OP_BOUND: verdict_in = 1'b1;
         OP_DINIT: begin
            rem_in = '0;
            quo_in = n_ff;
            cnt_in = CNT_WIDTH'(NUM_WIDTH);
         end
         OP_DSTEP: begin
            rem_in = (rem_shift >= d_ff) ? rem_shift - d_ff : rem_shift;
            quo_in = quo_ff << 1;
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         OP_RTEST: begin
            verdict_in = 1'b0;
            d_in       = d_ff + NUM_WIDTH'(1);
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      d_ff            <= d_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      cnt_ff          <= cnt_in;
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign req_stall    = (uw.op != OP_LOAD);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   `ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, pc_ff == STEP_SMALL, "accept did not start")
   `ASSERT_IMPLY(a_rem_below_div, pc_ff == STEP_DSTEP, rem_ff < d_ff, "remainder not below divisor")
   `ASSERT_IMPLY(a_prime_ge_two, pc_ff == STEP_FINISH && verdict_ff, !n_lt2, "prime verdict below two")
   `ASSERT_IMPLY(a_div_ge_two, pc_ff == STEP_RTEST, d_ff[NUM_WIDTH-1:1] != '0, "divisor below two")

endmodule
